[rtl/rcbp_pkg.sv]
// Package for the reference-counted buffer slot pool.
// Holds request and response types, command and status codes, and defaults.
// No dependencies.
package rcbp_pkg;

  localparam int DEF_SLOTS    = 64;
  localparam int DEF_REF_BITS = 16;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 6;
  localparam int SIZE_W  = 32;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd8;

  localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DROP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEANUP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  slot_index;
    logic [SIZE_W-1:0] request_size;
  } rcbp_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted_slot;
    logic [SIZE_W-1:0] slot_size_out;
    logic              slot_held_out;
  } rcbp_rsp_t;

endpackage

[rtl/refcounted_buffer_slot_pool.sv]
// Reference-counted buffer slot pool, top level. Depends on rcbp_pkg, rcbp_ram
// and rcbp_free_scan.
// A request is taken in the idle state; its response is registered as execution ends.
// One request is processed at a time: free-slot scan, table read, then update,
// so a new request is taken only once the block has returned to the idle state.
// Synchronous active-low reset empties the pool and restores capacity 8; no clearing pass.
module refcounted_buffer_slot_pool
  import rcbp_pkg::*;
#(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rcbp_req_t        in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output rcbp_rsp_t        out_rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  function automatic logic [CW-1:0] clamp_cap(input logic [31:0] c);
    logic [CW-1:0] r;
    if (c == 32'd0) begin
      r = CW'(1);
    end else if (c > 32'(SLOTS)) begin
      r = CW'(SLOTS);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  rcbp_req_t           req_r;
  logic [CW-1:0]       used_r;
  logic [CW-1:0]       used_nxt;
  logic [CW-1:0]       soft_r;
  logic [CW-1:0]       soft_nxt;
  logic [SLOTS-1:0]    held_r;
  logic [SLOTS-1:0]    held_nxt;
  logic [SLOTS-1:0]    zero_r;
  logic [SLOTS-1:0]    zero_nxt;
  logic                out_valid_r;
  rcbp_rsp_t           rsp_r;
  rcbp_rsp_t           rsp_nxt;

  logic                scan_found;
  logic [AW-1:0]       scan_slot;
  logic [SLOTS-1:0]    idle_map;

  logic [AW-1:0]       idx_a;
  logic [AW-1:0]       slot_a;
  logic [AW-1:0]       rd_addr;
  logic [SIZE_W-1:0]   size_rd;
  logic [REF_BITS-1:0] ref_rd;
  logic                size_we;
  logic                ref_we;
  logic [REF_BITS-1:0] ref_wd;
  logic                fire;
  logic                in_range;
  logic                at_cap;
  logic                full;
  logic                reuse;
  logic                held_o;
  logic [CW:0]         soft_dbl;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign idx_a    = AW'(req_r.slot_index);
  assign slot_a   = scan_found ? scan_slot : AW'(used_r);
  assign rd_addr  = (req_r.cmd == CMD_GET) ? slot_a : idx_a;
  assign in_range = (32'(req_r.slot_index) < 32'(used_r)) &&
                    (32'(req_r.slot_index) < 32'(SLOTS));
  assign at_cap   = (used_r >= soft_r);
  assign full     = (used_r == CW'(SLOTS));
  assign soft_dbl = {soft_r, 1'b0};

  rcbp_free_scan #(
    .SLOTS(SLOTS)
  ) u_scan (
    .clk       (clk),
    .en        (state_r == S_SCAN),
    .zero_map  (zero_r),
    .used_count(used_r),
    .found     (scan_found),
    .slot      (scan_slot),
    .idle_map  (idle_map)
  );

  rcbp_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(SLOTS)
  ) u_size_ram (
    .clk  (clk),
    .we   (size_we),
    .waddr(slot_a),
    .wdata(req_r.request_size),
    .re   (state_r == S_READ),
    .raddr(rd_addr),
    .rdata(size_rd)
  );

  rcbp_ram #(
    .WIDTH(REF_BITS),
    .DEPTH(SLOTS)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ref_we),
    .waddr(rd_addr),
    .wdata(ref_wd),
    .re   (state_r == S_READ),
    .raddr(rd_addr),
    .rdata(ref_rd)
  );

  always_comb begin
    held_nxt = held_r;
    zero_nxt = zero_r;
    used_nxt = used_r;
    soft_nxt = soft_r;
    size_we  = 1'b0;
    ref_we   = 1'b0;
    ref_wd   = REF_ONE;
    reuse    = held_r[slot_a] && (size_rd >= req_r.request_size);
    held_o   = 1'b0;
    rsp_nxt  = '0;
    rsp_nxt.status       = ST_OK;
    rsp_nxt.granted_slot = req_r.slot_index;
    case (req_r.cmd)
      CMD_GET: begin
        if (!scan_found && full) begin
          rsp_nxt.status       = ST_FULL;
          rsp_nxt.granted_slot = '0;
        end else begin
          if (!scan_found) begin
            used_nxt = used_r + CW'(1);
            if (at_cap) begin
              soft_nxt = clamp_cap(32'(soft_dbl));
            end
          end
          ref_we           = 1'b1;
          size_we          = !(scan_found && reuse);
          held_nxt[slot_a] = 1'b1;
          zero_nxt[slot_a] = 1'b0;
          rsp_nxt.granted_slot  = IDX_W'(slot_a);
          rsp_nxt.slot_held_out = 1'b1;
          rsp_nxt.slot_size_out = (scan_found && reuse) ? size_rd : req_r.request_size;
        end
      end
      CMD_CLEANUP: begin
        held_nxt = held_r & ~idle_map;
        held_o   = held_r[idx_a] && !idle_map[idx_a];
        if (in_range) begin
          rsp_nxt.slot_held_out = held_o;
          rsp_nxt.slot_size_out = held_o ? size_rd : '0;
        end
      end
      CMD_ADD, CMD_DROP, CMD_QUERY: begin
        if (!in_range) begin
          rsp_nxt.status = ST_RANGE;
        end else begin
          if (req_r.cmd == CMD_ADD && ref_rd != REF_MAX) begin
            ref_we          = 1'b1;
            ref_wd          = ref_rd + REF_ONE;
            zero_nxt[idx_a] = 1'b0;
          end
          if (req_r.cmd == CMD_DROP && ref_rd != '0) begin
            ref_we = 1'b1;
            ref_wd = ref_rd - REF_ONE;
            if (ref_rd == REF_ONE) begin
              zero_nxt[idx_a] = 1'b1;
              if (at_cap) begin
                held_nxt[idx_a] = 1'b0;
              end
            end
          end
          held_o = held_nxt[idx_a];
          rsp_nxt.slot_held_out = held_o;
          rsp_nxt.slot_size_out = held_o ? size_rd : '0;
        end
      end
      default: begin
        rsp_nxt.status = ST_OK;
      end
    endcase
    if (!fire) begin
      size_we = 1'b0;
      ref_we  = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      soft_r      <= clamp_cap(32'(CAP_RESET));
      held_r      <= '0;
      zero_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        soft_r <= clamp_cap(32'(cfg_wdata));
      end else if (fire) begin
        soft_r <= soft_nxt;
      end
      if (fire) begin
        used_r      <= used_nxt;
        held_r      <= held_nxt;
        zero_r      <= zero_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

endmodule

[rtl/rcbp_ram.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
// Used for the slot size table and the reference count table. No dependencies.
module rcbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rcbp_free_scan.sv]
// Registered search for the first used slot with zero references.
// Also registers the mask of idle used slots. Depends on nothing else.
module rcbp_free_scan #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [SLOTS-1:0]           zero_map,
  input  logic [$clog2(SLOTS+1)-1:0] used_count,
  output logic                       found,
  output logic [$clog2(SLOTS)-1:0]   slot,
  output logic [SLOTS-1:0]           idle_map
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0] idle_nxt;
  logic             found_nxt;
  logic [AW-1:0]    slot_nxt;
  logic             found_r;
  logic [AW-1:0]    slot_r;
  logic [SLOTS-1:0] idle_r;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      idle_nxt[i] = zero_map[i] && (CW'(i) < used_count);
    end
    found_nxt = |idle_nxt;
    slot_nxt  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (idle_nxt[i]) begin
        slot_nxt = AW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      found_r <= found_nxt;
      slot_r  <= slot_nxt;
      idle_r  <= idle_nxt;
    end
  end

  assign found    = found_r;
  assign slot     = slot_r;
  assign idle_map = idle_r;

endmodule
